// ===== rtl/core/brs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package brs_pkg;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned OP_W    = 2;

  // operation codes carried on the input tuser
  localparam logic [OP_W-1:0] OP_SEGMENT_BYTE  = 2'd0;
  localparam logic [OP_W-1:0] OP_EMPTY_SEGMENT = 2'd1;
  localparam logic [OP_W-1:0] OP_CONSUMER_READ = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/brs_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none

module brs_ring #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [ADDR_W-1:0]            wr_addr,
  input  wire logic [brs_pkg::BYTE_W-1:0]   wr_data,
  input  wire logic                         rd_en,
  input  wire logic [ADDR_W-1:0]            rd_addr,
  output logic      [brs_pkg::BYTE_W-1:0]   rd_data
);

  // byte storage, one write and one registered read per cycle
  logic [brs_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/byte_stream_reassembler_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// byte stream reassembler
// input channel s_axis: one item is a segment byte, an empty segment or a
//   consumer read (kind on tuser); the end-of-stream flag rides on tlast
// output channel m_axis: results of one item, one drained in-order byte per
//   result, or a single status result when nothing drains; tlast marks the
//   final result of the item, tuser says whether a byte is carried
// every result shows pending count and the ended flag as they stand once the
//   whole item is done
// timing: after an item is taken the head of the ring is scanned one slot a
//   cycle up to the first hole or the whole ring; each byte of the run then
//   passes a ring read and the output register, where it waits out any
//   receiver stall; a status result is set straight from the scan when the
//   run is empty, with no ring read
// the block takes one item at a time: s_axis_tready is high only when the
//   previous item's results have all been taken
// the slot-by-slot scan and the registered ring read set this timing
// reset clears the valid map, counters and flags at once; no clearing pass
// a stalled receiver simply holds the current result and the block waits

module byte_stream_reassembler_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // position[31:0], data_byte[39:32], read_count[46:40]
  input  wire logic [1:0]  s_axis_tuser,  // operation[1:0]
  input  wire logic        s_axis_tlast,  // end_flag
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // out_byte[7:0], stream_ended[8], pending_count[15:9]
  output logic             m_axis_tuser,  // byte_valid
  output logic             m_axis_tlast   // last_result
);

  localparam int unsigned SLOT_W = $clog2(CAPACITY);
  localparam int unsigned CW     = brs_pkg::COUNT_W;
  localparam int unsigned PW     = brs_pkg::POS_W;
  localparam logic [CW-1:0]     CAP_C      = CW'(CAPACITY);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(CAPACITY - 1);
  localparam logic [SLOT_W:0]   CAP_WIDE   = (SLOT_W+1)'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_SHOW
  } state_t;

  state_t state;

  // reassembly state
  logic [CAPACITY-1:0] valid;
  logic [SLOT_W-1:0]   head;
  logic [PW-1:0]       assembled;
  logic [CW-1:0]       pending;
  logic [CW-1:0]       fill;
  logic                end_seen;
  logic                ended;

  // sequencer state
  logic [SLOT_W-1:0]   scan_slot;
  logic [CW-1:0]       run;
  logic [CW-1:0]       remaining;
  logic                byte_flag;
  logic                last_flag;

  // input fields
  logic [brs_pkg::OP_W-1:0]   in_op;
  logic [PW-1:0]              in_pos;
  logic [brs_pkg::BYTE_W-1:0] in_byte;
  logic [CW-1:0]              in_read;

  assign in_op   = s_axis_tuser;
  assign in_pos  = s_axis_tdata[31:0];
  assign in_byte = s_axis_tdata[39:32];
  assign in_read = s_axis_tdata[46:40];

  logic accept;
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // window check against the free room of the output buffer
  logic [CW-1:0]     room;
  logic [PW-1:0]     offset;
  logic              in_window;
  logic              behind;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] wr_slot;
  logic              store_byte;

  assign room      = (fill < CAP_C) ? (CAP_C - fill) : '0;
  assign offset    = in_pos - assembled;
  assign in_window = offset < PW'(room);
  assign behind    = offset[PW-1];

  // offset < capacity here, so one compare and subtract wraps the slot
  assign slot_sum = (SLOT_W+1)'(head) + offset[SLOT_W:0];
  assign wr_slot  = (slot_sum >= CAP_WIDE) ? SLOT_W'(slot_sum - CAP_WIDE)
                                           : slot_sum[SLOT_W-1:0];

  assign store_byte = accept && (in_op == brs_pkg::OP_SEGMENT_BYTE) && in_window;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  // end of the head run: hole found or whole ring covered
  logic scan_more;
  assign scan_more = valid[scan_slot] && (run != CAP_C);

  logic [CW-1:0] pending_after;
  assign pending_after = (pending > run) ? (pending - run) : '0;

  // byte ring
  logic [brs_pkg::BYTE_W-1:0] rd_data;

  brs_ring #(
    .DEPTH  (CAPACITY),
    .ADDR_W (SLOT_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (store_byte),
    .wr_addr (wr_slot),
    .wr_data (in_byte),
    .rd_en   (state == S_READ),
    .rd_addr (head),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      valid         <= '0;
      head          <= '0;
      assembled     <= '0;
      pending       <= '0;
      fill          <= '0;
      end_seen      <= 1'b0;
      ended         <= 1'b0;
      scan_slot     <= '0;
      run           <= '0;
      remaining     <= '0;
      byte_flag     <= 1'b0;
      last_flag     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_op) inside
              brs_pkg::OP_SEGMENT_BYTE, brs_pkg::OP_EMPTY_SEGMENT: begin
                // end flag counts inside the window or behind the stream
                if (s_axis_tlast && (in_window || behind)) begin
                  end_seen <= 1'b1;
                end
                if (store_byte) begin
                  valid[wr_slot] <= 1'b1;
                  if (!valid[wr_slot]) begin
                    pending <= pending + 1'b1;
                  end
                end
              end
              brs_pkg::OP_CONSUMER_READ: begin
                fill <= (in_read >= fill) ? '0 : (fill - in_read);
              end
              default: begin
              end
            endcase
            scan_slot <= head;
            run       <= '0;
            state     <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (scan_more) begin
            run       <= run + 1'b1;
            scan_slot <= slot_inc(scan_slot);
          end else begin
            // run known: status fields take their final values now
            pending   <= pending_after;
            if (end_seen && (pending_after == '0)) begin
              ended <= 1'b1;
            end
            remaining <= run;
            if (run == '0) begin
              byte_flag     <= 1'b0;
              last_flag     <= 1'b1;
              m_axis_tvalid <= 1'b1;
              state         <= S_SHOW;
            end else begin
              state <= S_READ;
            end
          end
        end

        S_READ: begin
          byte_flag     <= 1'b1;
          last_flag     <= (remaining == CW'(1));
          m_axis_tvalid <= 1'b1;
          state         <= S_SHOW;
        end

        S_SHOW: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (byte_flag) begin
              valid[head] <= 1'b0;
              head        <= slot_inc(head);
              assembled   <= assembled + 1'b1;
              if (fill < CAP_C) begin
                fill <= fill + 1'b1;
              end
              remaining   <= remaining - 1'b1;
              state       <= (remaining == CW'(1)) ? S_IDLE : S_READ;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload
  assign m_axis_tdata = {pending, ended, (byte_flag ? rd_data : '0)};
  assign m_axis_tuser = byte_flag;
  assign m_axis_tlast = last_flag;

  // checks
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= CAP_C)
    else $error("pending count above capacity");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CAP_C)
    else $error("output fill above capacity");

  a_drain_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHOW) && byte_flag |-> valid[head])
    else $error("draining a slot that holds no byte");

  a_read_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (remaining != '0))
    else $error("ring read with no bytes left in the run");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result is still shown");

endmodule

`default_nettype wire

// ===== test/tb_byte_stream_reassembler_unit.sv =====
`timescale 1ns / 1ps

module tb_byte_stream_reassembler_unit;

  localparam int CAPACITY   = 64;
  localparam int QUIET_MAX  = 5000;  // cycles without any handshake before giving up
  localparam int SETTLE     = 150;   // cycles kept open after the last result
  localparam int RANDOM_LEN = 292;

  // the one operation code the package leaves unnamed; the block ignores it
  localparam logic [brs_pkg::OP_W-1:0] OP_UNKNOWN = 2'd3;

  typedef enum logic [1:0] {
    MIX_RX_HEAVY,  // sender idles lightly, receiver heavily
    MIX_TX_HEAVY,  // the other way round
    MIX_NONE       // nobody idles
  } idle_mix_t;

  typedef struct packed {
    logic [brs_pkg::OP_W-1:0]    op;
    logic [brs_pkg::POS_W-1:0]   pos;
    logic [brs_pkg::BYTE_W-1:0]  data;
    logic                        end_flag;
    logic [brs_pkg::COUNT_W-1:0] rd;
    logic                        hold;  // wait for every outstanding result before sending
    idle_mix_t                   mix;
  } stim_t;

  typedef struct packed {
    logic                        byte_valid;
    logic [brs_pkg::BYTE_W-1:0]  out_byte;
    logic                        last_result;
    logic                        stream_ended;
    logic [brs_pkg::COUNT_W-1:0] pending_count;
  } result_t;

  typedef struct packed {
    logic [63:0][7:0]            ring;
    logic [63:0]                 vmap;
    logic [5:0]                  head;
    logic [31:0]                 done_total;
    logic [brs_pkg::COUNT_W-1:0] pend;
    logic [brs_pkg::COUNT_W-1:0] fill;
    logic                        end_seen;
    logic                        ended;
  } reasm_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  stim_t        input_items[$];
  result_t      expected_stream[$];
  reasm_state_t plan_state;   // tracks the block while the stimulus is built
  reasm_state_t live_state;   // tracks the block as items are accepted
  idle_mix_t    plan_mix = MIX_RX_HEAVY;
  logic         plan_hold = 1'b0;
  idle_mix_t    mix_now = MIX_RX_HEAVY;
  int           items_total = 0;
  int           items_taken = 0;
  int           results_seen = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;

  byte_stream_reassembler_unit #(.CAPACITY(CAPACITY)) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // place one item in the window, then move the contiguous head run out
  task automatic reassemble(inout reasm_state_t st, input stim_t it, input bit record);
    int              room;
    int              slot;
    logic [31:0]     offset;
    logic [7:0]      run[$];
    result_t         res;
    room = CAPACITY - int'(st.fill);
    if (room < 0) room = 0;
    offset = it.pos - st.done_total;
    if (it.op == brs_pkg::OP_SEGMENT_BYTE || it.op == brs_pkg::OP_EMPTY_SEGMENT) begin
      if (offset < 32'(room)) begin
        if (it.op == brs_pkg::OP_SEGMENT_BYTE) begin
          slot = (int'(st.head) + int'(offset)) % CAPACITY;
          if (!st.vmap[slot]) st.pend = st.pend + 1'b1;
          st.ring[slot] = it.data;
          st.vmap[slot] = 1'b1;
        end
        if (it.end_flag) st.end_seen = 1'b1;
      end else if (offset[31] && it.end_flag) begin
        // behind the stream: nothing stored but the end still counts
        st.end_seen = 1'b1;
      end
    end else if (it.op == brs_pkg::OP_CONSUMER_READ) begin
      st.fill = (it.rd >= st.fill) ? '0 : st.fill - it.rd;
    end
    while (run.size() < CAPACITY && st.vmap[st.head]) begin
      run = {run, st.ring[st.head]};
      st.vmap[st.head] = 1'b0;
      st.head = 6'((int'(st.head) + 1) % CAPACITY);
      st.done_total = st.done_total + 1;
      if (st.pend != 0) st.pend = st.pend - 1'b1;
      if (st.fill < CAPACITY) st.fill = st.fill + 1'b1;
    end
    if (st.end_seen && st.pend == 0) st.ended = 1'b1;
    if (record) begin
      res.stream_ended  = st.ended;
      res.pending_count = st.pend;
      if (run.size() == 0) begin
        res.byte_valid  = 1'b0;
        res.out_byte    = '0;
        res.last_result = 1'b1;
        expected_stream = {expected_stream, res};
      end else begin
        foreach (run[i]) begin
          res.byte_valid  = 1'b1;
          res.out_byte    = run[i];
          res.last_result = (i == run.size() - 1);
          expected_stream = {expected_stream, res};
        end
      end
    end
  endtask

  task automatic plan(input logic [brs_pkg::OP_W-1:0] op, input logic [31:0] pos,
                      input logic [7:0] data, input logic endf, input logic [6:0] rd);
    stim_t it;
    it.op       = op;
    it.pos      = pos;
    it.data     = data;
    it.end_flag = endf;
    it.rd       = rd;
    it.hold     = plan_hold;
    it.mix      = plan_mix;
    plan_hold   = 1'b0;
    input_items = {input_items, it};
    reassemble(plan_state, it, 1'b0);
  endtask

  function automatic int idle_pct(input idle_mix_t mix, input bit sender);
    case (mix)
      MIX_RX_HEAVY: return sender ? 15 : 47;
      MIX_TX_HEAVY: return sender ? 47 : 15;
      default:      return 0;
    endcase
  endfunction

  // driver: next item goes out once the current one is taken
  always @(posedge clk) begin
    stim_t nxt;
    bit    go;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      go = 1'b0;
      if (input_items.size() != 0) begin
        nxt = input_items[0];
        if (nxt.hold)
          go = !s_axis_tvalid && expected_stream.size() == 0;
        else
          go = $urandom_range(0, 99) >= idle_pct(nxt.mix, 1'b1);
      end
      if (go) begin
        input_items.delete(0);
        s_axis_tdata  <= {1'b0, nxt.rd, nxt.data, nxt.pos};
        s_axis_tuser  <= nxt.op;
        s_axis_tlast  <= nxt.end_flag;
        s_axis_tvalid <= 1'b1;
        mix_now       <= nxt.mix;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= $urandom_range(0, 99) >= idle_pct(mix_now, 1'b0);
  end

  // monitor: predict on each accepted item, then check each accepted result
  always @(posedge clk) begin
    stim_t   seen;
    result_t got;
    result_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        seen.op       = s_axis_tuser;
        seen.pos      = s_axis_tdata[31:0];
        seen.data     = s_axis_tdata[39:32];
        seen.rd       = s_axis_tdata[46:40];
        seen.end_flag = s_axis_tlast;
        seen.hold     = 1'b0;
        seen.mix      = MIX_NONE;
        reassemble(live_state, seen, 1'b1);
        items_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.byte_valid    = m_axis_tuser;
        got.out_byte      = m_axis_tdata[7:0];
        got.last_result   = m_axis_tlast;
        got.stream_ended  = m_axis_tdata[8];
        got.pending_count = m_axis_tdata[15:9];
        if (expected_stream.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d unexpected: valid=%0b byte=%02h last=%0b ended=%0b pending=%0d",
                     results_seen, got.byte_valid, got.out_byte, got.last_result,
                     got.stream_ended, got.pending_count);
        end else begin
          want = expected_stream[0];
          expected_stream.delete(0);
          if (got.byte_valid !== want.byte_valid || got.out_byte !== want.out_byte ||
              got.last_result !== want.last_result || got.stream_ended !== want.stream_ended ||
              got.pending_count !== want.pending_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result %0d: expected valid=%0b byte=%02h last=%0b ended=%0b ",
                        "pending=%0d, got valid=%0b byte=%02h last=%0b ended=%0b pending=%0d"},
                       results_seen, want.byte_valid, want.out_byte, want.last_result,
                       want.stream_ended, want.pending_count, got.byte_valid, got.out_byte,
                       got.last_result, got.stream_ended, got.pending_count);
          end
        end
        results_seen++;
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("byte_stream_reassembler_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          counted;
    int          room;
    int          len;
    int          order_kind;
    int          pick;
    int          next_full;
    int          tmp;
    int          j;
    int          order[$];
    logic [31:0] base;
    logic [6:0]  rd;
    logic        end_ok;

    plan_state = '0;
    live_state = '0;

    // directed: reset status, unknown code, reordering, rewrite, window edges
    plan_hold = 1'b1;
    plan(brs_pkg::OP_CONSUMER_READ, 32'd0, 8'h00, 1'b0, 7'd0);
    plan(OP_UNKNOWN, 32'hDEAD_BEEF, 8'hFF, 1'b1, 7'd64);
    plan(brs_pkg::OP_SEGMENT_BYTE, 32'd0, 8'h00, 1'b0, 7'd0);
    plan(brs_pkg::OP_SEGMENT_BYTE, 32'd2, 8'hFF, 1'b0, 7'd0);
    plan(brs_pkg::OP_SEGMENT_BYTE, 32'd3, 8'hA5, 1'b0, 7'd0);
    plan(brs_pkg::OP_SEGMENT_BYTE, 32'd3, 8'h5A, 1'b0, 7'd0);    // rewrite of a held byte
    plan(brs_pkg::OP_SEGMENT_BYTE, 32'd1, 8'h3C, 1'b0, 7'd0);    // closes the gap, three drain
    plan(brs_pkg::OP_SEGMENT_BYTE, 32'd0, 8'h77, 1'b0, 7'd0);    // already assembled
    plan(brs_pkg::OP_SEGMENT_BYTE, 32'hFFFF_FFFF, 8'hFF, 1'b0, 7'd0);
    plan(brs_pkg::OP_EMPTY_SEGMENT, 32'd204, 8'h00, 1'b1, 7'd0); // beyond window, end ignored
    plan(brs_pkg::OP_SEGMENT_BYTE, 32'h8000_0003, 8'h11, 1'b1, 7'd0); // farthest ahead
    plan(brs_pkg::OP_SEGMENT_BYTE, 32'd64, 8'h22, 1'b0, 7'd0);   // first slot past the room
    plan(brs_pkg::OP_SEGMENT_BYTE, 32'd63, 8'h33, 1'b0, 7'd0);   // last slot inside the room
    plan_hold = 1'b1;
    plan(brs_pkg::OP_CONSUMER_READ, 32'd0, 8'h00, 1'b0, 7'd64);  // more than the buffer holds
    plan(brs_pkg::OP_SEGMENT_BYTE, 32'd67, 8'h44, 1'b0, 7'd0);
    plan(brs_pkg::OP_EMPTY_SEGMENT, 32'd5, 8'h00, 1'b0, 7'd0);
    plan(brs_pkg::OP_SEGMENT_BYTE, 32'd4, 8'h80, 1'b0, 7'd0);
    plan(brs_pkg::OP_CONSUMER_READ, 32'd0, 8'h00, 1'b0, 7'd1);

    // random: mostly in-window bursts, with reads, noise and late end flags
    counted   = 0;
    next_full = 40;
    while (counted < RANDOM_LEN) begin
      if (counted < RANDOM_LEN / 3) begin
        plan_mix = MIX_RX_HEAVY;
      end else if (counted < 2 * RANDOM_LEN / 3) begin
        if (plan_mix != MIX_TX_HEAVY) plan_hold = 1'b1;
        plan_mix = MIX_TX_HEAVY;
      end else begin
        if (plan_mix != MIX_NONE) plan_hold = 1'b1;
        plan_mix = MIX_NONE;
      end
      end_ok = counted > 230;
      room   = CAPACITY - int'(plan_state.fill);
      pick   = $urandom_range(0, 99);

      if (counted >= next_full) begin
        // empty the buffer and send a whole window back to front
        next_full += 90;
        plan(brs_pkg::OP_CONSUMER_READ, $urandom, 8'($urandom), 1'b0, 7'd64);
        counted++;
        len        = CAPACITY;
        order_kind = 1;
        pick       = -1;
      end

      if (pick < 50 && room >= 1) begin
        if (pick >= 0) begin
          len        = $urandom_range(1, (room < 8) ? room : 8);
          order_kind = $urandom_range(0, 2);
        end
        base = plan_state.done_total;
        order.delete();
        for (j = 0; j < len; j++) order = {order, (order_kind == 1) ? len - 1 - j : j};
        if (order_kind == 2) begin
          for (j = 0; j < len; j++) begin
            pick       = $urandom_range(0, len - 1);
            tmp        = order[j];
            order[j]   = order[pick];
            order[pick] = tmp;
          end
        end
        for (j = 0; j < len; j++) begin
          plan(brs_pkg::OP_SEGMENT_BYTE, base + 32'(order[j]), 8'($urandom),
               end_ok && order[j] == len - 1 && $urandom_range(0, 7) == 0, 7'($urandom));
          if (j == 0 && len > 1 && $urandom_range(0, 5) == 0) begin
            plan(brs_pkg::OP_SEGMENT_BYTE, base + 32'(order[0]), 8'($urandom), 1'b0, 7'd0);
            counted++;
          end
        end
        counted += len;
      end else if (pick < 72) begin
        case ($urandom_range(0, 3))
          0:       rd = 7'($urandom_range(0, 64));
          1:       rd = plan_state.fill;
          2:       rd = 7'd64;
          default: rd = 7'($urandom_range(0, int'(plan_state.fill) / 2));
        endcase
        plan(brs_pkg::OP_CONSUMER_READ, $urandom, 8'($urandom), 1'($urandom), rd);
        counted++;
      end else if (pick < 82) begin
        plan(brs_pkg::OP_EMPTY_SEGMENT, plan_state.done_total + 32'($urandom_range(0, room)),
             8'($urandom), end_ok && $urandom_range(0, 5) == 0, 7'($urandom));
        counted++;
      end else if (pick < 90) begin
        // behind the stream, near or anywhere
        if ($urandom_range(0, 1) == 0)
          base = plan_state.done_total - 32'($urandom_range(1, 300));
        else
          base = $urandom;
        plan($urandom_range(0, 1) == 0 ? brs_pkg::OP_SEGMENT_BYTE : brs_pkg::OP_EMPTY_SEGMENT,
             base, 8'($urandom), end_ok && $urandom_range(0, 7) == 0, 7'($urandom));
        counted++;
      end else if (pick < 96) begin
        // ahead of the window: dropped along with its end flag
        if ($urandom_range(0, 1) == 0)
          base = plan_state.done_total + 32'(room) + 32'($urandom_range(0, 3));
        else
          base = plan_state.done_total + 32'(room) +
                 32'($urandom_range(0, 32'h7FFF_FFFF - room));
        plan(brs_pkg::OP_SEGMENT_BYTE, base, 8'($urandom), 1'($urandom), 7'($urandom));
        counted++;
      end else begin
        plan(OP_UNKNOWN, $urandom, 8'($urandom), 1'($urandom), 7'($urandom));
        counted++;
      end
    end
    items_total = input_items.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (!(items_taken == items_total && expected_stream.size() == 0)) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && expected_stream.size() == 0)
      $display("byte_stream_reassembler_unit: match");
    else
      $display("byte_stream_reassembler_unit: mismatch");
    $finish;
  end

endmodule
